// ===== rtl/core/irf_pkg.sv =====
// Package for the image rotate/flip core: sizes, register and mode codes,
// and the command struct passed from controller to datapath.
// Used by every file of the core; depends on nothing.
package irf_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int PIXEL_BITS = 24;

    localparam int COORD_BITS = 6;   // column or row counter
    localparam int SIZE_BITS  = 7;   // width or height register
    localparam int ADDR_BITS  = 12;  // frame store address
    localparam int PROD_BITS  = 14;  // address arithmetic
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;
    localparam int MODE_BITS  = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_NONE  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_CW    = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_CCW   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_FLIPH = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_FLIPV = 3'd4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(MAX_WIDTH);

    typedef struct packed {
        logic load_en;   // write the accepted pixel into the store
        logic read_en;   // read the next output pixel from the store
        logic out_load;  // move the fetched pixel into the output register
    } irf_cmd_t;

endpackage

// ===== rtl/core/irf_in_if.sv =====
// Input item channel of the image rotate/flip core.
// Depends on irf_pkg for the pixel width.
interface irf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [irf_pkg::PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output operation, output pixel_in, input ready);
    modport sink   (input valid, input operation, input pixel_in, output ready);
endinterface

// ===== rtl/core/irf_out_if.sv =====
// Result channel of the image rotate/flip core.
// Depends on irf_pkg for the pixel width.
interface irf_out_if;
    logic                          valid;
    logic                          ready;
    logic [irf_pkg::PIXEL_BITS-1:0] pixel_out;
    logic                          last;

    modport source (output valid, output pixel_out, output last, input ready);
    modport sink   (input valid, input pixel_out, input last, output ready);
endinterface

// ===== rtl/core/irf_cfg_if.sv =====
// Configuration write channel of the image rotate/flip core.
// Depends on irf_pkg for the index and data widths.
interface irf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [irf_pkg::CFG_INDEX_BITS-1:0] index;
    logic [irf_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/image_rotate_flip_core.sv =====
// Image rotate/flip core: a load word is taken every cycle while no read is
// pending and written to the frame store at its transformed address at the edge
// that accepts it. A read word passes the store read register, then the output
// register; no new item is taken until it has moved on, and it waits while the
// output register holds a word not taken.
// Reset returns the registers to mode none, 64 x 64, and zeroes the counters;
// the frame store is not cleared and needs no clearing pass.
module image_rotate_flip_core (
    input  logic clk,
    input  logic rst_n,
    irf_cfg_if.sink cfg,
    irf_in_if.sink  items,
    irf_out_if.source results
);
    import irf_pkg::*;

    irf_cmd_t cmd;
    logic     cfg_write;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    irf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (items.valid),
        .in_operation (items.operation),
        .in_ready     (items.ready),
        .out_ready    (results.ready),
        .out_valid    (results.valid),
        .cmd          (cmd)
    );

    irf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_write (cfg_write),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .pixel_in  (items.pixel_in),
        .pixel_out (results.pixel_out),
        .last      (results.last)
    );
endmodule

// ===== rtl/core/irf_ctrl.sv =====
// Controller of the image rotate/flip core: accepts items and sequences
// the store read and the output register. Depends on irf_pkg.
module irf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_operation,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output irf_pkg::irf_cmd_t cmd
);
    import irf_pkg::*;

    typedef enum logic {S_IDLE, S_FETCH} state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd.load_en  = accept && (in_operation == OP_LOAD);
        cmd.read_en  = accept && (in_operation == OP_READ);
        cmd.out_load = 1'b0;
        state_next   = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.read_en)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                // The fetched word waits here until the output register frees up.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_read_fetches: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_en |=> (state_reg == S_FETCH))
        else $error("read accepted without entering fetch");

    a_load_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("output register loaded but no valid word");

    a_no_accept_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !cmd.load_en && !cmd.read_en)
        else $error("item accepted while a read is pending");

    a_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("output word overwritten before it was taken");
endmodule

// ===== rtl/core/irf_datapath.sv =====
// Datapath of the image rotate/flip core: configuration registers, load and
// read counters, destination address unit, frame store and output register.
// Depends on irf_pkg; driven by the command struct from irf_ctrl.
module irf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  irf_pkg::irf_cmd_t                   cmd,
    input  logic                                cfg_write,
    input  logic [irf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [irf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [irf_pkg::PIXEL_BITS-1:0]      pixel_in,
    output logic [irf_pkg::PIXEL_BITS-1:0]      pixel_out,
    output logic                                last
);
    import irf_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [MODE_BITS-1:0]  mode_reg;
    logic [SIZE_BITS-1:0]  width_reg;
    logic [SIZE_BITS-1:0]  height_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [COORD_BITS-1:0] col_next;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] row_next;
    logic [ADDR_BITS-1:0]  rd_idx_reg;
    logic [ADDR_BITS-1:0]  rd_idx_next;

    logic [PIXEL_BITS-1:0] store [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] rdata_reg;
    logic                  rlast_reg;
    logic [PIXEL_BITS-1:0] pixel_out_reg;
    logic                  last_reg;

    logic [SIZE_BITS-1:0]  cfg_limit;
    logic [SIZE_BITS-1:0]  cfg_size;
    logic [PROD_BITS-1:0]  x_e, y_e, w_e, h_e, xr_e, yr_e;
    logic [PROD_BITS-1:0]  mul_a, mul_b, add_c, dest;
    logic [PROD_BITS-1:0]  total;
    logic                  col_wrap, row_wrap, is_last;

    // Sizes are clamped when written: zero acts as one, oversize as the maximum.
    always_comb
    begin
        cfg_limit = (cfg_index == REG_HEIGHT) ? SIZE_BITS'(MAX_HEIGHT)
                                              : SIZE_BITS'(MAX_WIDTH);
        if (cfg_data == '0)
            cfg_size = SIZE_BITS'(1);
        else if (cfg_data > cfg_limit)
            cfg_size = cfg_limit;
        else
            cfg_size = cfg_data;
    end

    assign x_e  = PROD_BITS'(col_reg);
    assign y_e  = PROD_BITS'(row_reg);
    assign w_e  = PROD_BITS'(width_reg);
    assign h_e  = PROD_BITS'(height_reg);
    assign xr_e = w_e - PROD_BITS'(1) - x_e;
    assign yr_e = h_e - PROD_BITS'(1) - y_e;

    always_comb
    begin
        case (mode_reg)
            MODE_CW:    begin mul_a = xr_e; mul_b = h_e; add_c = y_e;  end
            MODE_CCW:   begin mul_a = x_e;  mul_b = h_e; add_c = yr_e; end
            MODE_FLIPH: begin mul_a = y_e;  mul_b = w_e; add_c = xr_e; end
            MODE_FLIPV: begin mul_a = yr_e; mul_b = w_e; add_c = x_e;  end
            default:    begin mul_a = y_e;  mul_b = w_e; add_c = x_e;  end
        endcase
    end

    assign dest  = mul_a * mul_b + add_c;
    assign total = w_e * h_e;

    assign col_wrap = ({1'b0, col_reg} + SIZE_BITS'(1)) == width_reg;
    assign row_wrap = ({1'b0, row_reg} + SIZE_BITS'(1)) == height_reg;
    assign is_last  = (PROD_BITS'(rd_idx_reg) + PROD_BITS'(1)) == total;

    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.load_en)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + COORD_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
        if (cmd.read_en)
        begin
            rd_idx_next = is_last ? '0 : rd_idx_reg + ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else if (cfg_write)
        begin
            // Any write to a known register restarts the frame.
            unique case (cfg_index)
                REG_MODE:
                begin
                    mode_reg   <= cfg_data[MODE_BITS-1:0];
                    col_reg    <= '0;
                    row_reg    <= '0;
                    rd_idx_reg <= '0;
                end
                REG_WIDTH:
                begin
                    width_reg  <= cfg_size;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    rd_idx_reg <= '0;
                end
                REG_HEIGHT:
                begin
                    height_reg <= cfg_size;
                    col_reg    <= '0;
                    row_reg    <= '0;
                    rd_idx_reg <= '0;
                end
                default:
                begin
                    col_reg    <= col_next;
                    row_reg    <= row_next;
                    rd_idx_reg <= rd_idx_next;
                end
            endcase
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            store[dest[ADDR_BITS-1:0]] <= pixel_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            rdata_reg <= store[rd_idx_reg];
            rlast_reg <= is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_out_reg <= rdata_reg;
            last_reg      <= rlast_reg;
        end
    end

    assign pixel_out = pixel_out_reg;
    assign last      = last_reg;
endmodule

// ===== verif/irf_frame_checker.sv =====
// Checker for the image rotate/flip core: keeps its own copy of the frame
// store and counters, predicts every read word and compares the result channel.
// Depends on irf_pkg and the three channel interfaces.
module irf_frame_checker (
    input  logic clk,
    input  logic rst_n,
    irf_cfg_if   cfg,
    irf_in_if    items,
    irf_out_if   results,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import irf_pkg::*;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  last;
    } out_word_t;

    out_word_t             expected_pixels[$];
    logic [PIXEL_BITS-1:0] frame_copy [MAX_WIDTH*MAX_HEIGHT];
    logic [MODE_BITS-1:0]  cur_mode;
    logic [SIZE_BITS-1:0]  cur_width;
    logic [SIZE_BITS-1:0]  cur_height;
    int                    load_x;
    int                    load_y;
    int                    read_pos;

    // A size of zero acts as one, anything above the maximum as the maximum.
    function automatic int frame_dim(input logic [SIZE_BITS-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    // Unknown mode codes fall back to a straight copy.
    function automatic int dest_addr(input logic [MODE_BITS-1:0] m,
                                     input int x, input int y, input int w, input int h);
        case (m)
            MODE_CW:    return (w - 1 - x) * h + y;
            MODE_CCW:   return x * h + (h - 1 - y);
            MODE_FLIPH: return y * w + (w - 1 - x);
            MODE_FLIPV: return (h - 1 - y) * w + x;
            default:    return y * w + x;
        endcase
    endfunction

    task automatic log_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict
        int        w;
        int        h;
        int        x;
        int        y;
        int        addr;
        out_word_t want;
        if (!rst_n)
        begin
            cur_mode   = MODE_NONE;
            cur_width  = SIZE_RESET;
            cur_height = SIZE_RESET;
            load_x     = 0;
            load_y     = 0;
            read_pos   = 0;
            expected_pixels.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MODE:   cur_mode   = cfg.data[MODE_BITS-1:0];
                    REG_WIDTH:  cur_width  = cfg.data;
                    REG_HEIGHT: cur_height = cfg.data;
                    default:    ;
                endcase
                // A write to a real register starts a new frame.
                if (cfg.index inside {REG_MODE, REG_WIDTH, REG_HEIGHT})
                begin
                    load_x   = 0;
                    load_y   = 0;
                    read_pos = 0;
                end
            end

            w = frame_dim(cur_width, MAX_WIDTH);
            h = frame_dim(cur_height, MAX_HEIGHT);

            if (items.valid && items.ready)
            begin
                if (items.operation == OP_LOAD)
                begin
                    x = (load_x < w) ? load_x : w - 1;
                    y = (load_y < h) ? load_y : h - 1;
                    frame_copy[dest_addr(cur_mode, x, y, w, h)] = items.pixel_in;
                    if (x + 1 >= w)
                    begin
                        load_x = 0;
                        load_y = (y + 1 >= h) ? 0 : y + 1;
                    end
                    else
                    begin
                        load_x = x + 1;
                        load_y = y;
                    end
                end
                else
                begin
                    addr = (read_pos < w * h) ? read_pos : w * h - 1;
                    want.pixel = frame_copy[addr];
                    want.last  = (addr + 1 >= w * h);
                    expected_pixels.push_back(want);
                    read_pos = want.last ? 0 : addr + 1;
                end
            end

            if (results.valid && results.ready)
            begin
                if (expected_pixels.size() == 0)
                    log_mismatch($sformatf("unexpected word pixel_out=%h last=%b",
                                           results.pixel_out, results.last));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (results.pixel_out !== want.pixel)
                        log_mismatch($sformatf("pixel_out %h, expected %h",
                                               results.pixel_out, want.pixel));
                    if (results.last !== want.last)
                        log_mismatch($sformatf("last %b, expected %b",
                                               results.last, want.last));
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ===== verif/image_rotate_flip_core_tb.sv =====
// Testbench top for the image rotate/flip core: clock, reset, register setup,
// frame loads and reads with random stalls; the checker judges the words.
// Depends on irf_pkg, the channel interfaces, the core and irf_frame_checker.
module image_rotate_flip_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irf_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED_A = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED_B = 3'd7;
    localparam int NUM_PHASES = 12;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   phase_no;
    int   fail_count;
    int   pending;

    irf_cfg_if cfg_ch ();
    irf_in_if  item_ch ();
    irf_out_if res_ch ();

    image_rotate_flip_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .items   (item_ch),
        .results (res_ch)
    );

    irf_frame_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .items      (item_ch),
        .results    (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Result side back-pressure.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [CFG_DATA_BITS-1:0] mode_word(input logic [MODE_BITS-1:0] m);
        logic [CFG_DATA_BITS-MODE_BITS-1:0] hi;
        // The upper data bits are don't-care for the mode register.
        hi = (CFG_DATA_BITS-MODE_BITS)'($urandom_range(2**(CFG_DATA_BITS-MODE_BITS) - 1));
        return {hi, m};
    endfunction

    function automatic int frame_dim(input logic [CFG_DATA_BITS-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return int'(v);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_word(input logic op, input logic [PIXEL_BITS-1:0] pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.operation <= op;
        item_ch.pixel_in  <= pix;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Registers may only change once every read word has come back and the
    // last load has had time to land in the store.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One frame: set the registers, load a whole frame so that every read
    // address holds data, then mix loads and reads.
    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] mode_data,
                             input logic [CFG_DATA_BITS-1:0] wdata,
                             input logic [CFG_DATA_BITS-1:0] hdata,
                             input int n_mixed, input int read_pct);
        int w;
        int h;
        case (phase_no * 3 / NUM_PHASES)
            0:
            begin
                send_idle_pct  = 30;
                recv_stall_pct = 73;
            end
            1:
            begin
                send_idle_pct  = 73;
                recv_stall_pct = 30;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
        phase_no++;

        wait_idle();
        if ($urandom_range(3) == 0)
            write_reg(REG_SPARE, CFG_DATA_BITS'($urandom_range(127)));
        write_reg(REG_MODE, mode_data);
        write_reg(REG_WIDTH, wdata);
        write_reg(REG_HEIGHT, hdata);
        cfg_ch.valid <= 1'b0;

        w = frame_dim(wdata, MAX_WIDTH);
        h = frame_dim(hdata, MAX_HEIGHT);
        for (int i = 0; i < w * h; i++)
        begin
            if (i == 0)
                send_word(OP_LOAD, '0);
            else if (i == w * h - 1)
                send_word(OP_LOAD, '1);
            else
                send_word(OP_LOAD, PIXEL_BITS'($urandom_range(2**PIXEL_BITS - 1)));
        end
        for (int i = 0; i < n_mixed; i++)
        begin
            if ($urandom_range(99) < read_pct)
                send_word(OP_READ, PIXEL_BITS'($urandom_range(2**PIXEL_BITS - 1)));
            else
                send_word(OP_LOAD, PIXEL_BITS'($urandom_range(2**PIXEL_BITS - 1)));
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_MODE;
        cfg_ch.data       <= '0;
        item_ch.valid     <= 1'b0;
        item_ch.operation <= OP_LOAD;
        item_ch.pixel_in  <= '0;
        send_idle_pct      = 30;
        recv_stall_pct     = 73;
        phase_no           = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Small directed frames: a rotation read past its end so the read
        // index wraps, then an unknown mode with a zero width.
        run_phase(mode_word(MODE_CW), 7'd3, 7'd2, 7, 100);
        run_phase(mode_word(MODE_UNUSED_A), 7'd0, 7'd2, 4, 50);

        run_phase(mode_word(MODE_NONE), 7'd5, 7'd4, 20, 50);
        run_phase(mode_word(MODE_CW), 7'd32, 7'd2, 20, 50);
        run_phase(mode_word(MODE_CCW), 7'd2, 7'd64, 20, 50);
        run_phase(mode_word(MODE_FLIPH), 7'd7, 7'd5, 20, 50);
        run_phase(mode_word(MODE_FLIPV), 7'd4, 7'd7, 20, 50);
        run_phase(mode_word(MODE_UNUSED_B), 7'd127, 7'd0, 20, 50);
        run_phase(mode_word(MODE_CCW), 7'd6, 7'd6, 20, 50);
        run_phase(mode_word(MODE_CW), 7'd1, 7'd1, 20, 50);
        for (int k = 0; k < NUM_PHASES - 10; k++)
            run_phase(mode_word(MODE_BITS'($urandom_range(7))),
                      CFG_DATA_BITS'($urandom_range(1, 9)),
                      CFG_DATA_BITS'($urandom_range(1, 9)), 20, 50);

        wait_idle();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
